### hdl/uud_pkg.sv
// Shared types and constants for the uudecode line stream block.
// Used by every module of the block; depends on nothing else.
package uud_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PTR_W = 2;
	localparam int unsigned QUEUE_CNT_W = 3;

	localparam logic [7:0] CHAR_BIAS = 8'h20;
	localparam logic [7:0] CHAR_MAX  = 8'h7f;

	typedef struct packed {
		logic [7:0] ch;
		logic       line_end;
	} char_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last_byte;
	} byte_item_t;

endpackage

### hdl/uudecode_line_stream.sv
// Top level of the uudecode line stream block: front, byte queue and output stage.
// Depends on uud_pkg, uud_front, uud_queue and uud_back.
//
// Takes one character of a uuencoded line per clock cycle and gives zero or one decoded
// byte for it. The length character and the first digit of each group give no byte; the
// other three digits each give one until the declared count is used, and the byte that
// uses it up carries last_byte. A line-end character resets the line state after it is
// decoded. A byte is written into the four-entry byte queue at the edge that accepts its
// character and moves into the output register from the queue head once that register is
// empty or its byte is taken. The character channel stalls only while that queue is full,
// so it sustains one character per cycle as long as the byte channel takes bytes.
module uudecode_line_stream (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_stall,
	input  uud_pkg::char_item_t char_item,
	output logic                byte_valid,
	input  logic                byte_stall,
	output uud_pkg::byte_item_t byte_item
);
	import uud_pkg::*;

	logic       push;
	byte_item_t push_item;
	logic       queue_full;
	logic       head_valid;
	byte_item_t head_item;
	logic       pop;

	uud_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	uud_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop)
	);

	uud_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item)
	);

endmodule

### hdl/uud_front.sv
// Front part: accepts characters, tracks the line state and forms decoded bytes.
// Depends on uud_pkg for the item types and character constants.
module uud_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_stall,
	input  uud_pkg::char_item_t char_item,
	input  logic                queue_full,
	output logic                push,
	output uud_pkg::byte_item_t push_item
);
	import uud_pkg::*;

	typedef enum logic [2:0] {
		PH_LENGTH = 3'd0,
		PH_D1     = 3'd1,
		PH_D2     = 3'd2,
		PH_D3     = 3'd3,
		PH_D4     = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	phase_t     phase_q;
	logic [6:0] remaining_q;
	logic [5:0] held_q;

	logic       accept;
	logic [7:0] unbiased;
	logic [5:0] digit;
	logic       emit;
	logic [7:0] byte_val;
	logic       fire;
	logic       last;

	assign char_stall = queue_full;
	assign accept     = char_valid && !char_stall;
	assign unbiased   = char_item.ch - CHAR_BIAS;
	assign digit      = unbiased[5:0];

	always_comb begin
		emit     = 1'b0;
		byte_val = 8'h00;
		case (phase_q)
			PH_D2: begin
				emit     = 1'b1;
				byte_val = {held_q, digit[5:4]};
			end
			PH_D3: begin
				emit     = 1'b1;
				byte_val = {held_q[3:0], digit[5:2]};
			end
			PH_D4: begin
				emit     = 1'b1;
				byte_val = {held_q[1:0], digit};
			end
			default: begin
				emit     = 1'b0;
				byte_val = 8'h00;
			end
		endcase
	end

	assign fire      = accept && emit && (remaining_q != 7'd0);
	assign last      = (remaining_q == 7'd1);
	assign push      = fire;
	assign push_item = '{data: byte_val, last_byte: last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LENGTH;
			remaining_q <= 7'd0;
			held_q      <= 6'd0;
		end else if (accept) begin
			if (char_item.line_end) begin
				phase_q     <= PH_LENGTH;
				remaining_q <= 7'd0;
				held_q      <= 6'd0;
			end else begin
				case (phase_q)
					PH_LENGTH: begin
						if (char_item.ch inside {[CHAR_BIAS:CHAR_MAX]} &&
						    unbiased[6:0] != 7'd0) begin
							remaining_q <= unbiased[6:0];
							phase_q     <= PH_D1;
						end else begin
							remaining_q <= 7'd0;
							phase_q     <= PH_DONE;
						end
					end
					PH_D1: begin
						held_q  <= digit;
						phase_q <= PH_D2;
					end
					PH_D2: begin
						held_q  <= digit;
						phase_q <= PH_D3;
					end
					PH_D3: begin
						held_q  <= digit;
						phase_q <= PH_D4;
					end
					PH_D4: begin
						held_q  <= 6'd0;
						phase_q <= PH_D1;
					end
					default: begin
						phase_q <= phase_q;
					end
				endcase
				if (fire) begin
					remaining_q <= remaining_q - 7'd1;
					if (last) begin
						phase_q <= PH_DONE;
					end
				end
			end
		end
	end

endmodule

### hdl/uud_queue.sv
// Short queue of decoded bytes between the front and back parts.
// Depends on uud_pkg for the byte item type and queue sizing.
module uud_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  uud_pkg::byte_item_t push_item,
	output logic                full,
	output logic                head_valid,
	output uud_pkg::byte_item_t head_item,
	input  logic                pop
);
	import uud_pkg::*;

	byte_item_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [QUEUE_CNT_W-1:0]   count_q;
	logic                     do_pop;

	assign full       = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/uud_back.sv
// Back part: output register that presents decoded bytes to the byte channel.
// Depends on uud_pkg for the byte item type.
module uud_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  uud_pkg::byte_item_t head_item,
	output logic                pop,
	output logic                byte_valid,
	input  logic                byte_stall,
	output uud_pkg::byte_item_t byte_item
);
	import uud_pkg::*;

	logic       out_valid_q;
	byte_item_t out_item_q;

	assign pop        = head_valid && (!out_valid_q || !byte_stall);
	assign byte_valid = out_valid_q;
	assign byte_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !byte_stall) begin
			out_valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_item_q <= head_item;
		end
	end

endmodule

### dv/tb_uudecode_line_stream.sv
`timescale 1ns / 1ps
// Self-checking testbench for uudecode_line_stream: directed and random uuencoded lines
// with random idling on both channels. Depends on uud_pkg and the block's RTL.
module tb_uudecode_line_stream;

	import uud_pkg::*;

	typedef enum logic [2:0] {
		PH_LENGTH = 3'd0,
		PH_DIGIT1 = 3'd1,
		PH_DIGIT2 = 3'd2,
		PH_DIGIT3 = 3'd3,
		PH_DIGIT4 = 3'd4,
		PH_DONE   = 3'd5
	} line_phase_t;

	localparam int RANDOM_ITEMS = 1525;
	localparam int CALM_TAIL    = 150;
	localparam int HOLD_AFTER   = 400;
	localparam int HOLD_CYCLES  = 400;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       char_valid = 1'b0;
	logic       char_stall;
	char_item_t char_item = '0;
	logic       byte_valid;
	logic       byte_stall = 1'b0;
	byte_item_t byte_item;

	char_item_t  pending_chars[$];
	byte_item_t  expected_bytes[$];

	line_phase_t line_phase = PH_LENGTH;
	logic [6:0]  bytes_left = '0;
	logic [5:0]  held_digit = '0;

	logic calm = 1'b0;
	logic hold_active = 1'b0;
	logic hold_done = 1'b0;
	int   hold_count = 0;
	int   hold_seen_chars = 0;
	int   full_stall_cycles = 0;

	int send_gap = 0;
	int send_seg = 0;
	int send_pct = 0;
	int stall_gap = 0;
	int stall_seg = 0;
	int stall_pct = 0;

	int chars_taken = 0;
	int lines_taken = 0;
	int bytes_seen = 0;
	int mismatches = 0;

	uudecode_line_stream i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int pick_idle_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 5;
			2: return 20;
			default: return 50;
		endcase
	endfunction

	function automatic logic [7:0] rand_digit_char();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 90)
			return 8'($urandom_range(8'h20, 8'h5f));
		else if (sel < 95)
			return 8'h60;
		else
			return 8'($urandom_range(0, 255));
	endfunction

	task automatic queue_char(input logic [7:0] c, input logic le);
		char_item_t it;
		it.ch = c;
		it.line_end = le;
		pending_chars.push_back(it);
	endtask

	// Advances the line state by one character and records the byte it yields, if any.
	task automatic decode_char(input char_item_t c);
		logic [7:0] diff;
		logic [5:0] dig;
		logic [7:0] val;
		logic       emit;
		byte_item_t b;
		diff = c.ch - CHAR_BIAS;
		dig = diff[5:0];
		val = '0;
		emit = 1'b0;
		case (line_phase)
			PH_LENGTH: begin
				if (c.ch >= CHAR_BIAS && c.ch <= CHAR_MAX)
					bytes_left = diff[6:0];
				else
					bytes_left = '0;
				line_phase = (bytes_left != 0) ? PH_DIGIT1 : PH_DONE;
			end
			PH_DIGIT1: begin
				held_digit = dig;
				line_phase = PH_DIGIT2;
			end
			PH_DIGIT2: begin
				val = {held_digit, dig[5:4]};
				held_digit = dig;
				emit = 1'b1;
				line_phase = PH_DIGIT3;
			end
			PH_DIGIT3: begin
				val = {held_digit[3:0], dig[5:2]};
				held_digit = dig;
				emit = 1'b1;
				line_phase = PH_DIGIT4;
			end
			PH_DIGIT4: begin
				val = {held_digit[1:0], dig};
				held_digit = '0;
				emit = 1'b1;
				line_phase = PH_DIGIT1;
			end
			default: ;
		endcase
		if (emit && bytes_left != 0) begin
			bytes_left = bytes_left - 7'd1;
			b.data = val;
			b.last_byte = (bytes_left == 0);
			expected_bytes.push_back(b);
			if (bytes_left == 0)
				line_phase = PH_DONE;
		end
		if (c.line_end) begin
			line_phase = PH_LENGTH;
			bytes_left = '0;
			held_digit = '0;
		end
	endtask

	always @(posedge clk) begin : char_driver
		logic       nxt_valid;
		char_item_t nxt_item;
		nxt_valid = char_valid && char_stall;
		nxt_item = char_item;
		if (send_seg == 0) begin
			send_seg = $urandom_range(50, 300);
			send_pct = pick_idle_pct();
		end else begin
			send_seg--;
		end
		if (arst_n && !nxt_valid) begin
			if (send_gap != 0) begin
				send_gap--;
			end else if (pending_chars.size() != 0) begin
				if (!calm && !hold_active && $urandom_range(0, 99) < send_pct) begin
					send_gap = $urandom_range(0, 18);
				end else begin
					nxt_item = pending_chars.pop_front();
					nxt_valid = 1'b1;
				end
			end
		end
		calm <= (pending_chars.size() < CALM_TAIL);
		char_valid <= nxt_valid;
		char_item <= nxt_item;
	end

	always @(posedge clk) begin : byte_monitor
		byte_item_t want;
		logic       nxt_stall;
		if (arst_n && char_valid && !char_stall) begin
			decode_char(char_item);
			chars_taken++;
			if (char_item.line_end)
				lines_taken++;
		end
		if (arst_n && byte_valid && !byte_stall) begin
			bytes_seen++;
			if (expected_bytes.size() == 0) begin
				if (mismatches < 10)
					$display("tb: unexpected byte %02h last %0b with nothing pending",
						byte_item.data, byte_item.last_byte);
				mismatches++;
			end else begin
				want = expected_bytes.pop_front();
				if (byte_item.data !== want.data || byte_item.last_byte !== want.last_byte) begin
					if (mismatches < 10)
						$display("tb: byte %0d expected data %02h last %0b, got data %02h last %0b",
							bytes_seen, want.data, want.last_byte, byte_item.data,
							byte_item.last_byte);
					mismatches++;
				end
			end
		end
		if (stall_seg == 0) begin
			stall_seg = $urandom_range(50, 300);
			stall_pct = pick_idle_pct();
		end else begin
			stall_seg--;
		end
		if (hold_active) begin
			nxt_stall = 1'b1;
		end else if (stall_gap != 0) begin
			stall_gap--;
			nxt_stall = 1'b1;
		end else if (arst_n && !calm && $urandom_range(0, 99) < stall_pct) begin
			stall_gap = $urandom_range(0, 18);
			nxt_stall = 1'b1;
		end else begin
			nxt_stall = 1'b0;
		end
		byte_stall <= nxt_stall;
	end

	// One long stall on the byte side while characters keep coming.
	always @(posedge clk) begin : byte_hold_off
		if (arst_n) begin
			if (char_valid && !char_stall)
				hold_seen_chars <= hold_seen_chars + 1;
			if (char_valid && char_stall)
				full_stall_cycles <= full_stall_cycles + 1;
			if (hold_active) begin
				hold_count <= hold_count - 1;
				if (hold_count == 1)
					hold_active <= 1'b0;
			end else if (!hold_done && hold_seen_chars >= HOLD_AFTER) begin
				hold_active <= 1'b1;
				hold_done <= 1'b1;
				hold_count <= HOLD_CYCLES;
			end
		end
	end

	initial begin : stimulus
		int kind;
		int n;
		int groups;
		int k;
		int extra;
		int useful;
		int guard;
		logic [7:0] c;

		// "Cat", then a line-end character after the count is used up.
		queue_char(8'h23, 1'b0);
		queue_char(8'h30, 1'b0);
		queue_char(8'h56, 1'b0);
		queue_char(8'h25, 1'b0);
		queue_char(8'h54, 1'b0);
		queue_char(8'h0a, 1'b1);
		// Zero length, then invalid lengths.
		queue_char(8'h20, 1'b0);
		queue_char(8'h41, 1'b0);
		queue_char(8'h42, 1'b1);
		queue_char(8'h80, 1'b0);
		queue_char(8'h41, 1'b1);
		queue_char(8'hff, 1'b1);
		// Largest length with out-of-range digits, cut short after one group.
		queue_char(8'h7f, 1'b0);
		queue_char(8'h60, 1'b0);
		queue_char(8'hff, 1'b0);
		queue_char(8'h00, 1'b0);
		queue_char(8'h5f, 1'b1);
		// Count used up on the character that ends the line.
		queue_char(8'h22, 1'b0);
		queue_char(8'h21, 1'b0);
		queue_char(8'h7e, 1'b0);
		queue_char(8'h78, 1'b1);
		// A length character that ends its own line, and an invalid length of zero.
		queue_char(8'h21, 1'b1);
		queue_char(8'h00, 1'b0);
		queue_char(8'h7f, 1'b1);

		useful = 0;
		while (useful < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 75) begin
				if ($urandom_range(0, 15) == 0)
					n = $urandom_range(46, 95);
				else
					n = $urandom_range(1, 45);
				groups = (n + 2) / 3;
				extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
				queue_char(8'(CHAR_BIAS + n), 1'b0);
				for (int i = 0; i < groups * 4; i++)
					queue_char(rand_digit_char(), extra == 0 && i == groups * 4 - 1);
				for (int i = 0; i < extra; i++)
					queue_char(8'($urandom_range(0, 255)), i == extra - 1);
				useful += 1 + groups * 4;
			end else if (kind < 87) begin
				n = $urandom_range(1, 45);
				groups = (n + 2) / 3;
				k = $urandom_range(0, groups * 4 - 1);
				queue_char(8'(CHAR_BIAS + n), k == 0);
				for (int i = 0; i < k; i++)
					queue_char(rand_digit_char(), i == k - 1);
				useful += 1 + k;
			end else if (kind < 93) begin
				case ($urandom_range(0, 2))
					0: c = CHAR_BIAS;
					1: c = 8'($urandom_range(8'h00, 8'h1f));
					default: c = 8'($urandom_range(8'h80, 8'hff));
				endcase
				extra = $urandom_range(0, 4);
				queue_char(c, extra == 0);
				for (int i = 0; i < extra; i++)
					queue_char(8'($urandom_range(0, 255)), i == extra - 1);
				useful += 1;
			end else begin
				extra = $urandom_range(1, 8);
				for (int i = 0; i < extra; i++)
					queue_char(8'($urandom_range(0, 255)),
						i == extra - 1 || $urandom_range(0, 3) == 0);
				useful += extra;
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_chars.size() != 0 || char_valid)
			@(negedge clk);
		guard = 0;
		while (expected_bytes.size() != 0 && guard < 2000) begin
			@(negedge clk);
			guard++;
		end
		repeat (10) @(negedge clk);
		if (expected_bytes.size() != 0) begin
			$display("tb: %0d expected bytes never arrived", expected_bytes.size());
			mismatches += expected_bytes.size();
		end

		$display("tb: %0d characters over %0d lines decoded into %0d checked bytes",
			chars_taken, lines_taken, bytes_seen);
		$display("tb: character channel stalled %0d cycles, mostly under a long byte hold-off",
			full_stall_cycles);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : watchdog
		#5000000;
		$display("tb: failure");
		$finish;
	end

endmodule
